/* rtl/core/sorted_id_table_unit_defines.svh */
// assertion macros for the sorted id table unit
// no dependencies
`ifndef SORTED_ID_TABLE_UNIT_DEFINES_SVH
`define SORTED_ID_TABLE_UNIT_DEFINES_SVH
`define SIT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/sit_pkg.sv */
// shared types and codes for the sorted id table
// no dependencies
`timescale 1ns / 1ps
package sit_pkg;
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic start;
        logic srch_step;
        logic shift_step;
        logic write_key;
        logic finish;
    } sit_cmd_t;

    typedef struct packed {
        logic full;
        logic srch_done;
        logic shift_done;
    } sit_sts_t;
endpackage

/* rtl/core/sit_ctrl.sv */
// controller: sequences search, shift and result for each transaction
// depends on sit_pkg
`timescale 1ns / 1ps
module sit_ctrl import sit_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_kind,
    output logic     m_valid,
    input  logic     m_ready,
    input  sit_sts_t sts,
    output sit_cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SRCH = 3'd1, S_RD = 3'd2,
                           S_SHIFT = 3'd3, S_WR = 3'd4, S_OUT = 3'd5,
                           S_FETCH = 3'd6;
    logic [2:0] state_reg, state_next;
    logic kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg <= kind_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    kind_next = s_kind;
                    state_next = S_FETCH;
                end
            end
            // waits for the registered read of the probe entry
            S_FETCH: begin
                state_next = S_SRCH;
            end
            S_SRCH: begin
                if (kind_reg == KIND_INSERT && sts.full) begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end else if (sts.srch_done) begin
                    if (kind_reg == KIND_LOOKUP) begin
                        state_next = S_RD;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else begin
                    cmd.srch_step = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_RD: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = S_WR;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_WR: begin
                cmd.write_key = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* rtl/core/sit_dp.sv */
// datapath: entry memory, binary search, shift pipeline and result registers
// depends on sit_pkg
`timescale 1ns / 1ps
module sit_dp import sit_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_kind,
    input  logic [63:0] s_id,
    input  sit_cmd_t    cmd,
    output sit_sts_t    sts,
    output logic [1:0]  m_status,
    output logic [9:0]  m_position,
    output logic [10:0] m_entry_count
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH = CW'(MAX_ENTRIES);

    logic [63:0] mem [MAX_ENTRIES];
    logic [10:0] cap_reg;
    logic [CW-1:0] count_reg, lo_reg, hi_reg, sh_reg;
    logic [63:0] key_reg, rd_reg;
    logic kind_reg, rd_ok_reg, mv_reg;
    logic [AW-1:0] mv_addr_reg;
    logic [1:0] status_reg;
    logic [9:0] pos_reg;
    logic [10:0] outcnt_reg;

    logic [CW-1:0] mid, limit;
    logic [63:0] mid_v_reg;
    logic go_right;
    logic [CW-1:0] cap_ext;

    assign cap_ext = (CW >= 11) ? CW'(cap_reg) : ((cap_reg > 11'(MAX_ENTRIES)) ? DEPTH
                     : CW'(cap_reg));
    assign limit = (cap_ext < DEPTH) ? cap_ext : DEPTH;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = kind_reg ? (mid_v_reg < key_reg) : (mid_v_reg <= key_reg);

    assign sts.full = (count_reg >= limit);
    assign sts.srch_done = (lo_reg >= hi_reg);
    assign sts.shift_done = (sh_reg <= lo_reg) && !mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 11'd1024;
            count_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (cmd.write_key) count_reg <= count_reg + 1'b1;
            mv_reg <= cmd.shift_step && (sh_reg > lo_reg) && !mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mid_v_reg <= mem[mid[AW-1:0]];
        if (cmd.start) begin
            key_reg <= s_id;
            kind_reg <= s_kind;
            lo_reg <= '0;
            hi_reg <= count_reg;
            sh_reg <= count_reg;
        end
        if (cmd.srch_step) begin
            if (go_right) lo_reg <= mid + 1'b1;
            else hi_reg <= mid;
        end
        // read stage then write stage; a new entry is read only once the previous one is written
        if (cmd.shift_step && sh_reg > lo_reg && !mv_reg) begin
            rd_reg <= mem[sh_reg[AW-1:0] - 1'b1];
            mv_addr_reg <= sh_reg[AW-1:0];
            sh_reg <= sh_reg - 1'b1;
        end
        if (mv_reg) mem[mv_addr_reg] <= rd_reg;
        if (cmd.write_key) mem[lo_reg[AW-1:0]] <= key_reg;
        if (!cmd.finish) begin
            rd_ok_reg <= (lo_reg < count_reg);
        end
        if (cmd.finish) begin
            if (kind_reg == KIND_LOOKUP) begin
                if (rd_ok_reg && mid_v_reg == key_reg) begin
                    status_reg <= ST_FOUND;
                    pos_reg <= 10'(lo_reg);
                end else begin
                    status_reg <= ST_MISSING;
                    pos_reg <= '0;
                end
                outcnt_reg <= 11'(count_reg);
            end else if (cmd.write_key) begin
                status_reg <= ST_INSERTED;
                pos_reg <= 10'(lo_reg);
                outcnt_reg <= 11'(count_reg + 1'b1);
            end else begin
                status_reg <= ST_FULL;
                pos_reg <= '0;
                outcnt_reg <= 11'(count_reg);
            end
        end
    end

    assign m_status = status_reg;
    assign m_position = pos_reg;
    assign m_entry_count = outcnt_reg;
endmodule

/* rtl/core/sorted_id_table_unit.sv */
// channel   | ports                               | direction
// s (items) | s_valid s_ready s_kind s_id         | in
// m (result)| m_valid m_ready m_status m_position m_entry_count | out
// a lookup result follows the search and S_RD; probes <= log2(count)+1
// each binary search probe runs S_FETCH (registered read) then S_SRCH
// an insert then moves each larger entry up by a read and a write stage
// and writes the key in S_WR; a full insert ends in its first S_SRCH
// reset clears the count and sets capacity to 1024; memory contents are not cleared
// one transaction at a time; a stalled result holds until m_ready
// depends on sit_pkg, sit_ctrl, sit_dp and the defines header
`timescale 1ns / 1ps
`include "sorted_id_table_unit_defines.svh"
module sorted_id_table_unit import sit_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_position,
    output logic [10:0] m_entry_count
);
    sit_cmd_t cmd;
    sit_sts_t sts;

    sit_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    sit_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_kind(s_kind), .s_id(s_id), .cmd(cmd), .sts(sts), .m_status(m_status),
        .m_position(m_position), .m_entry_count(m_entry_count)
    );

    `SIT_ASSERT_IMPL(a_no_both, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `SIT_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status))
    `SIT_ASSERT_IMPL(a_insert_count, aclk, aresetn, m_valid && m_status == ST_INSERTED, m_entry_count != 11'd0)
endmodule
